/* hw/rtl/csrd_pkg.sv */
// Shared types, op codes and constants for the clamped stats block.
`timescale 1ns / 1ps
`default_nettype none

package csrd_pkg;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 3;
    localparam int OPND_W   = 32;
    localparam int VAL_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Rolling display thresholds and step sizes
    localparam logic [VAL_W-1:0]  SNAP_LIMIT = 31'd1000;
    localparam logic [VAL_W-1:0]  BIG_STEP   = 31'd100;
    localparam logic [VAL_W-1:0]  MID_STEP   = 31'd10;
    localparam logic [STEP_W-1:0] BIG_INC    = 7'd100;
    localparam logic [STEP_W-1:0] MID_INC    = 7'd10;
    localparam logic [STEP_W-1:0] ONE_INC    = 7'd1;

    // Ceiling reset values
    localparam logic [VAL_W-1:0] CEIL_RST_SLOT0 = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] CEIL_RST_SLOT1 = 31'h00FF_FF00;
    localparam logic [VAL_W-1:0] CEIL_RST_OTHER = 31'd256;

    // Command broadcast to every cell
    typedef struct packed {
        logic              fire;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [OPND_W-1:0] operand;
        logic              smooth;
    } cmd_t;

    // Configuration write broadcast to every cell
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [VAL_W-1:0]     data;
    } cfg_t;

    // Report carried from cell to cell along the chain
    typedef struct packed {
        logic             settled;
        logic [VAL_W-1:0] real_value;
        logic [VAL_W-1:0] shown_value;
        logic             at_min;
        logic             at_max;
    } report_t;

    function automatic logic [VAL_W-1:0] ceiling_reset(input logic [SLOT_W-1:0] id);
        logic [VAL_W-1:0] v;
        case (id)
            3'd0:    v = CEIL_RST_SLOT0;
            3'd1:    v = CEIL_RST_SLOT1;
            default: v = CEIL_RST_OTHER;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/csrd_cell.sv */
// One slot cell: real, shown and ceiling registers plus a report stage of the chain.
`timescale 1ns / 1ps
`default_nettype none

module csrd_cell #(
    parameter int SLOT_ID = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  csrd_pkg::cmd_t       cmd,
    input  csrd_pkg::cfg_t       cfg,
    input  csrd_pkg::report_t    rpt_in,
    output csrd_pkg::report_t    rpt_out
);

    localparam logic [csrd_pkg::SLOT_W-1:0] MY_ID = csrd_pkg::SLOT_W'(SLOT_ID);

    logic [csrd_pkg::VAL_W-1:0] real_reg,  real_next;
    logic [csrd_pkg::VAL_W-1:0] shown_reg, shown_next;
    logic [csrd_pkg::VAL_W-1:0] ceil_reg;
    logic                       fin_reg,   fin_next;
    csrd_pkg::report_t          rpt_reg,   rpt_next;

    logic                        hit;
    logic signed [32:0]          cand;
    logic [csrd_pkg::VAL_W-1:0]  clamped;
    logic [31:0]                 diff;
    logic [csrd_pkg::VAL_W-1:0]  mag;
    logic                        neg;
    logic [csrd_pkg::STEP_W-1:0] step;
    logic [csrd_pkg::VAL_W-1:0]  shown_rolled;

    assign hit = (cmd.slot == MY_ID);

    // Form the candidate value at full width and clamp to 0..ceiling
    always_comb begin
        if (cmd.op == csrd_pkg::OP_ADD) begin
            cand = $signed({2'b00, real_reg}) + $signed({cmd.operand[31], cmd.operand});
        end else begin
            cand = $signed({cmd.operand[31], cmd.operand});
        end
        if (cand[32]) begin
            clamped = '0;
        end else if (cand[31:0] > {1'b0, ceil_reg}) begin
            clamped = ceil_reg;
        end else begin
            clamped = cand[30:0];
        end
    end

    // Distance between real and shown, and the rolling step
    always_comb begin
        diff = {1'b0, real_reg} - {1'b0, shown_reg};
        neg  = diff[31];
        mag  = neg ? 31'(-diff) : diff[30:0];
        if (mag > csrd_pkg::BIG_STEP) begin
            step = csrd_pkg::BIG_INC;
        end else if (mag > csrd_pkg::MID_STEP) begin
            step = csrd_pkg::MID_INC;
        end else begin
            step = csrd_pkg::ONE_INC;
        end
        shown_rolled = neg ? shown_reg - csrd_pkg::VAL_W'(step)
                           : shown_reg + csrd_pkg::VAL_W'(step);
    end

    // Apply the command to this slot
    always_comb begin
        real_next  = real_reg;
        shown_next = shown_reg;
        fin_next   = fin_reg;
        if (cmd.fire) begin
            if ((cmd.op == csrd_pkg::OP_SET || cmd.op == csrd_pkg::OP_ADD) && hit) begin
                real_next = clamped;
            end else if (cmd.op == csrd_pkg::OP_TICK) begin
                if (!cmd.smooth || mag == '0 || mag > csrd_pkg::SNAP_LIMIT) begin
                    shown_next = real_reg;
                    fin_next   = 1'b1;
                end else begin
                    shown_next = shown_rolled;
                    fin_next   = 1'b0;
                end
            end
        end
    end

    // Merge this slot into the passing report
    always_comb begin
        rpt_next         = rpt_in;
        rpt_next.settled = rpt_in.settled & fin_reg;
        if (hit) begin
            rpt_next.real_value  = real_reg;
            rpt_next.shown_value = shown_reg;
            rpt_next.at_min      = (real_reg == '0);
            rpt_next.at_max      = (real_reg >= ceil_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_reg  <= '0;
            shown_reg <= '0;
            fin_reg   <= 1'b1;
            ceil_reg  <= csrd_pkg::ceiling_reset(MY_ID);
        end else begin
            real_reg  <= real_next;
            shown_reg <= shown_next;
            fin_reg   <= fin_next;
            if (cfg.we && cfg.index == MY_ID) begin
                ceil_reg <= cfg.data;
            end
        end
    end

    // Report stage advances every cycle
    always_ff @(posedge aclk) begin
        rpt_reg <= rpt_next;
    end

    assign rpt_out = rpt_reg;

endmodule

`default_nettype wire

/* hw/rtl/clamped_stats_with_rolling_display.sv */
// Top level: command sequencer, chain of slot cells and result register.
// Usage:
//   s_ channel: one beat carries op (set, add, tick), slot, operand_value and
//   smooth. A set or add writes the addressed slot's real value clamped to
//   0..ceiling; a tick rolls every slot's shown value toward its real value.
//   m_ channel: one result beat per input beat with the addressed slot's real
//   and shown values, at_min, at_max, and all_settled for a tick.
//   cfg channel: cfg_index selects a slot ceiling, cfg_data is its new value;
//   always ready; the user must write only while no item is in flight (not enforced).
// Timing: the block works on one item at a time. The command is applied to
//   all cells in the cycle after acceptance, then the report beat walks the
//   chain of NUM_SLOTS cells, one cell per cycle. The next input is taken the
//   cycle after the result is taken.
// Reset: aresetn low clears all real and shown values, restores the ceiling
//   defaults and drops m_valid.
// Stall: while m_ready is low the result beat holds and s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module clamped_stats_with_rolling_display #(
    parameter int NUM_SLOTS = 6
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [csrd_pkg::OP_W-1:0]       s_op,
    input  wire  [csrd_pkg::SLOT_W-1:0]     s_slot,
    input  wire  signed [csrd_pkg::OPND_W-1:0] s_operand_value,
    input  wire                             s_smooth,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [csrd_pkg::VAL_W-1:0]      m_real_value,
    output logic [csrd_pkg::VAL_W-1:0]      m_shown_value,
    output logic                            m_at_min,
    output logic                            m_at_max,
    output logic                            m_all_settled,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [csrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [csrd_pkg::VAL_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    csrd_pkg::cmd_t      cmd_reg;
    csrd_pkg::cmd_t      cmd_bcast;
    csrd_pkg::cfg_t      cfg_bcast;
    csrd_pkg::report_t   rpt [0:NUM_SLOTS];
    csrd_pkg::report_t   res_reg;
    logic                chain_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = (state_reg == ST_OUT);

    assign chain_done = (cnt_reg == CNT_W'(NUM_SLOTS));

    // Fire the held command into every cell for one cycle
    always_comb begin
        cmd_bcast      = cmd_reg;
        cmd_bcast.fire = (state_reg == ST_EXEC);
    end

    assign cfg_bcast.we    = cfg_valid & cfg_ready;
    assign cfg_bcast.index = cfg_index;
    assign cfg_bcast.data  = cfg_data;

    // Report enters the chain settled and empty
    assign rpt[0] = '{settled: 1'b1, real_value: '0, shown_value: '0,
                      at_min: 1'b0, at_max: 1'b0};

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            csrd_cell #(
                .SLOT_ID (g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd_bcast),
                .cfg     (cfg_bcast),
                .rpt_in  (rpt[g]),
                .rpt_out (rpt[g+1])
            );
        end
    endgenerate

    // Sequence one item: accept, apply, walk the chain, deliver
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (chain_done) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Capture the input beat and the finished report
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.fire    <= 1'b0;
            cmd_reg.op      <= s_op;
            cmd_reg.slot    <= s_slot;
            cmd_reg.operand <= s_operand_value;
            cmd_reg.smooth  <= s_smooth;
        end
        if (state_reg == ST_RUN && chain_done) begin
            res_reg <= rpt[NUM_SLOTS];
        end
    end

    assign m_real_value  = res_reg.real_value;
    assign m_shown_value = res_reg.shown_value;
    assign m_at_min      = res_reg.at_min;
    assign m_at_max      = res_reg.at_max;
    assign m_all_settled = res_reg.settled & (cmd_reg.op == csrd_pkg::OP_TICK);

endmodule

`default_nettype wire

/* hw/rtl/csrd_checker.sv */
// Port-level checks for the clamped stats block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csrd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [csrd_pkg::VAL_W-1:0]    m_real_value,
    input wire [csrd_pkg::VAL_W-1:0]    m_shown_value,
    input wire                          m_at_min
);

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_real_value) && $stable(m_shown_value))
        else $error("stalled result beat changed");

    // One item in flight: no input taken right after an input beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while item in flight");

    // No input taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    // at_min only on a zero real value
    a_min_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_at_min |-> m_real_value == '0)
        else $error("at_min with nonzero real value");

endmodule

bind clamped_stats_with_rolling_display csrd_checker u_csrd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_real_value  (m_real_value),
    .m_shown_value (m_shown_value),
    .m_at_min      (m_at_min)
);

`default_nettype wire

/* verif/tb_clamped_stats_with_rolling_display.sv */
// Self-checking testbench for the clamped stats block with rolling display.
`timescale 1ns / 1ps

module tb_clamped_stats_with_rolling_display;
    import csrd_pkg::*;

    localparam int NUM_SLOTS       = 6;
    localparam int RESET_CYCLES    = 3;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = NUM_SLOTS + 3;

    // Op code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Ceiling register indexes; the two above the last slot map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAY_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAY_HI   = 3'd7;

    localparam logic [VAL_W-1:0]  VAL_MAX = 31'h7FFF_FFFF;
    localparam logic [OPND_W-1:0] OPND_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OPND_W-1:0] OPND_NEG_MAX = 32'h8000_0000;

    // Predictor of slot state plus the queue of expected result beats
    class stats_scoreboard;
        logic [VAL_W-1:0] ceil_val  [NUM_SLOTS];
        logic [VAL_W-1:0] true_val  [NUM_SLOTS];
        logic [VAL_W-1:0] shown_val [NUM_SLOTS];
        report_t          expected_q[$];
        int               errors;

        function void reset_state();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                true_val[i]  = '0;
                shown_val[i] = '0;
                ceil_val[i]  = CEIL_RST_OTHER;
            end
            ceil_val[0] = CEIL_RST_SLOT0;
            ceil_val[1] = CEIL_RST_SLOT1;
            expected_q.delete();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Clamp a wide signed value into 0..ceiling of one slot
        function logic [VAL_W-1:0] clamp_to_slot(input int s, input longint v);
            longint top;
            top = longint'(ceil_val[s]);
            if (v < 0) v = 0;
            if (v > top) v = top;
            return v[VAL_W-1:0];
        endfunction

        // Move one shown value; return 1 when the slot counts as finished
        function bit roll_slot(input int s, input bit smooth_mode);
            longint           d;
            longint           mag;
            logic [VAL_W-1:0] stepv;
            d   = longint'(true_val[s]) - longint'(shown_val[s]);
            mag = (d < 0) ? -d : d;
            if (!smooth_mode || mag == 0 || mag > longint'(SNAP_LIMIT)) begin
                shown_val[s] = true_val[s];
                return 1'b1;
            end
            if (mag > longint'(BIG_STEP))      stepv = VAL_W'(BIG_INC);
            else if (mag > longint'(MID_STEP)) stepv = VAL_W'(MID_INC);
            else                               stepv = VAL_W'(ONE_INC);
            shown_val[s] = (d > 0) ? shown_val[s] + stepv : shown_val[s] - stepv;
            return 1'b0;
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VAL_W-1:0] data);
            if (idx < NUM_SLOTS) ceil_val[idx] = data;
        endfunction

        // Apply one accepted input beat and queue the result it must produce
        function void note_input(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                 input logic signed [OPND_W-1:0] opnd, input logic smooth_mode);
            report_t exp_beat;
            bit      all_done;
            bit      in_range;
            int      i;
            in_range = (slot < NUM_SLOTS);
            exp_beat = '0;
            case (op)
                OP_SET: begin
                    if (in_range) true_val[slot] = clamp_to_slot(slot, longint'(opnd));
                end
                OP_ADD: begin
                    if (in_range)
                        true_val[slot] = clamp_to_slot(slot,
                            longint'(true_val[slot]) + longint'(opnd));
                end
                OP_TICK: begin
                    all_done = 1'b1;
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (!roll_slot(i, smooth_mode)) all_done = 1'b0;
                    exp_beat.settled = all_done;
                end
                default: ;
            endcase
            if (in_range) begin
                exp_beat.real_value  = true_val[slot];
                exp_beat.shown_value = shown_val[slot];
                exp_beat.at_min      = (true_val[slot] == '0);
                exp_beat.at_max      = (true_val[slot] >= ceil_val[slot]);
            end
            expected_q.push_back(exp_beat);
        endfunction

        // Compare one result beat with the oldest expectation
        task check_result(input logic [VAL_W-1:0] rv, input logic [VAL_W-1:0] sv,
                          input logic mn, input logic mx, input logic st);
            report_t exp_beat;
            if (expected_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            exp_beat = expected_q.pop_front();
            if (rv !== exp_beat.real_value)
                report($sformatf("real_value got %0d exp %0d", rv, exp_beat.real_value));
            if (sv !== exp_beat.shown_value)
                report($sformatf("shown_value got %0d exp %0d", sv, exp_beat.shown_value));
            if (mn !== exp_beat.at_min)
                report($sformatf("at_min got %b exp %b", mn, exp_beat.at_min));
            if (mx !== exp_beat.at_max)
                report($sformatf("at_max got %b exp %b", mx, exp_beat.at_max));
            if (st !== exp_beat.settled)
                report($sformatf("all_settled got %b exp %b", st, exp_beat.settled));
        endtask
    endclass

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op    = '0;
    logic [SLOT_W-1:0]        s_slot  = '0;
    logic signed [OPND_W-1:0] s_operand_value = '0;
    logic                     s_smooth = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [VAL_W-1:0]         m_real_value;
    logic [VAL_W-1:0]         m_shown_value;
    logic                     m_at_min;
    logic                     m_at_max;
    logic                     m_all_settled;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [VAL_W-1:0]         cfg_data  = '0;

    stats_scoreboard  sb;
    int               idle_cycles = 0;
    bit               calm = 1'b0;
    logic [VAL_W-1:0] ceil_plan [NUM_SLOTS];

    clamped_stats_with_rolling_display #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_slot          (s_slot),
        .s_operand_value (s_operand_value),
        .s_smooth        (s_smooth),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_real_value    (m_real_value),
        .m_shown_value   (m_shown_value),
        .m_at_min        (m_at_min),
        .m_at_max        (m_at_max),
        .m_all_settled   (m_all_settled),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Mostly short gaps, a few long ones, none during a calm stretch
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Mostly valid slots, sometimes an index past the last slot
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) == 0) return SLOT_W'($urandom_range(NUM_SLOTS, 7));
        return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    endfunction

    // Present one input beat after a random gap and hold it until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [OPND_W-1:0] opnd, input logic smooth_mode);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_slot          <= slot;
        s_operand_value <= opnd;
        s_smooth        <= smooth_mode;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every expected result beat has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Present one register write beat; the caller drops cfg_valid afterwards
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Receiver: random stalls on the result channel
    initial begin
        int n;
        wait (aresetn === 1'b1);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Monitor: check result beats, predict from input beats, track config writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_real_value, m_shown_value, m_at_min, m_at_max, m_all_settled);
            if (s_valid && s_ready)
                sb.note_input(s_op, s_slot, s_operand_value, s_smooth);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_index, cfg_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int                       ph;
        int                       i;
        int                       done;
        int                       burst;
        int                       r;
        logic [OP_W-1:0]          op;
        logic [SLOT_W-1:0]        slot;
        logic signed [OPND_W-1:0] opnd;
        longint                   near_ceil;
        bit                       sm;

        sb = new();
        sb.reset_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with reset ceilings
        send_item(OP_TICK, 3'd0, '0, 1'b1);             // all at rest
        send_item(OP_SET,  3'd0, OPND_POS_MAX, 1'b0);   // full-range ceiling
        send_item(OP_ADD,  3'd0, OPND_POS_MAX, 1'b0);   // wide sum saturates
        send_item(OP_ADD,  3'd0, OPND_NEG_MAX, 1'b0);   // wide sum goes below zero
        send_item(OP_SET,  3'd1, OPND_POS_MAX, 1'b1);   // clamp to shifted ceiling
        send_item(OP_SET,  3'd1, OPND_NEG_MAX, 1'b1);   // most negative set
        send_item(OP_SET,  3'd2, 32'd300, 1'b0);
        send_item(OP_SET,  3'd3, 32'd5, 1'b0);
        send_item(OP_SET,  3'd4, 32'd150, 1'b0);
        send_item(OP_SET,  3'd0, 32'd5000, 1'b0);
        send_item(OP_SET,  3'd1, 32'd50, 1'b0);
        send_item(OP_SET,  3'd5, -32'sd7, 1'b0);
        send_item(OP_TICK, 3'd3, '0, 1'b1);             // snap and every step size
        send_item(OP_TICK, 3'd3, '0, 1'b1);
        send_item(OP_TICK, 3'd1, '0, 1'b1);
        send_item(OP_TICK, 3'd2, '0, 1'b0);             // immediate copy
        send_item(OP_SET,  3'd5, 32'd1, 1'b0);
        send_item(OP_TICK, 3'd5, '0, 1'b1);             // step lands exactly, not finished
        send_item(OP_TICK, 3'd5, '0, 1'b1);             // finished on the next tick
        send_item(OP_SET,  3'd4, '0, 1'b0);
        send_item(OP_TICK, 3'd4, '0, 1'b1);             // step downward
        send_item(OP_TICK, 3'd4, '0, 1'b1);
        send_item(OP_UNUSED, 3'd2, 32'd123, 1'b1);      // unused op code
        send_item(OP_SET,  3'd6, 32'd100, 1'b0);        // slot out of range
        send_item(OP_TICK, 3'd7, '0, 1'b1);
        send_item(OP_ADD,  3'd7, 32'd5, 1'b0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();

            // Choose this phase's ceilings; the first drops them all to zero
            for (i = 0; i < NUM_SLOTS; i++) begin
                case (ph)
                    0: ceil_plan[i] = '0;
                    1: ceil_plan[i] = VAL_MAX;
                    2: ceil_plan[i] = VAL_W'($urandom_range(0, 1500));
                    3: ceil_plan[i] = VAL_W'($urandom());
                    5: ceil_plan[i] = VAL_W'($urandom_range(1, 20));
                    default: begin
                        r = $urandom_range(0, 4);
                        if (r == 0)      ceil_plan[i] = '0;
                        else if (r == 1) ceil_plan[i] = VAL_MAX;
                        else if (r == 2) ceil_plan[i] = VAL_W'($urandom_range(0, 3000));
                        else if (r == 3) ceil_plan[i] = VAL_W'(1);
                        else             ceil_plan[i] = VAL_W'($urandom());
                    end
                endcase
                write_cfg(CFG_CEIL_FIRST + CFG_IDX_W'(i), ceil_plan[i]);
            end
            if (ph == 0 || ph == NUM_PHASES - 1) begin
                write_cfg(CFG_STRAY_LO, VAL_W'($urandom()));
                write_cfg(CFG_STRAY_HI, VAL_W'($urandom()));
            end
            cfg_valid <= 1'b0;

            // Random part: single beats mixed with bursts of ticks
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 49) == 0) calm = !calm;
                if ($urandom_range(0, 99) == 0) drain_results();
                if ($urandom_range(0, 99) < 12) begin
                    burst = $urandom_range(3, 12);
                    sm = ($urandom_range(0, 5) != 0);
                    repeat (burst) send_item(OP_TICK, pick_slot(), $urandom(), sm);
                    done += burst;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 40)      op = OP_SET;
                    else if (r < 78) op = OP_ADD;
                    else if (r < 95) op = OP_TICK;
                    else             op = OP_UNUSED;
                    slot = pick_slot();
                    near_ceil = (slot < NUM_SLOTS) ? longint'(sb.ceil_val[slot]) : 0;
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        opnd = OPND_W'(longint'($urandom_range(0, 3000)) - 1500);
                    else if (r < 45)
                        opnd = OPND_W'(near_ceil + longint'($urandom_range(0, 4)) - 2);
                    else if (r < 55) begin
                        case ($urandom_range(0, 4))
                            0:       opnd = OPND_POS_MAX;
                            1:       opnd = OPND_NEG_MAX;
                            2:       opnd = '0;
                            3:       opnd = -32'sd1;
                            default: opnd = 32'sd1;
                        endcase
                    end else if (r < 65)
                        opnd = OPND_W'(longint'($urandom_range(0, 40)) - 20);
                    else
                        opnd = $urandom();
                    send_item(op, slot, opnd, 1'($urandom_range(0, 1)));
                    done++;
                end
            end
        end

        // Wait out the last results, then a short quiet stretch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/csrd_pkg.sv
hw/rtl/csrd_cell.sv
hw/rtl/clamped_stats_with_rolling_display.sv
hw/rtl/csrd_checker.sv
verif/tb_clamped_stats_with_rolling_display.sv
